@@ src/gap_buffer_editor_macros.svh @@
// ----------------------------------------------------------------------------
// Gap buffer editor assertion macros
// Shared concurrent checks, clocked on the rising edge and masked in reset.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_EDITOR_MACROS_SVH
`define GAP_BUFFER_EDITOR_MACROS_SVH

// Check that cons holds whenever ante holds.
`define GBE_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gap buffer check failed");

// Check that cond holds at every edge out of reset.
`define GBE_ASSERT_HOLDS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("gap buffer invariant broken");

`endif

@@ src/gbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor package
// Operation codes, sequencer states, field widths and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int unsigned FIELD_W    = 13;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } gbe_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_MOVE,
    ST_FIN
  } gbe_state_t;

  // Result fields other than the payload length, which is taken at the end.
  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               read_valid;
    logic [FIELD_W-1:0] done_count;
    logic               full_res;
  } gbe_res_t;

endpackage

@@ src/gap_buffer_editor.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor
// Byte store of CAPACITY entries holding an editable payload with one gap.
// Flow: ST_DECODE, then ST_READ for a read inside the payload or ST_MOVE for
//   an accepted edit, then ST_FIN; ST_MOVE walks the gap to the offset one
//   byte copy at a time, then applies the edit (a delete on a full store jumps).
// One transaction at a time: in_tready is high only in ST_IDLE; stalls hold ST_FIN.
// Reset: rst_n clears gap start and payload size; the byte store keeps its
//   contents and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gap_buffer_editor_macros.svh"

module gap_buffer_editor
  import gbe_pkg::*;
#(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: op[1:0], offset[14:2], data_byte[22:15], length[35:23], zero[39:36]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: read_byte[7:0], read_valid[8], done_count[21:9],
  //            payload_length[34:22], full_res[35], zero[39:36]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Store address width, size width (holds CAPACITY itself) and compare width.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned W  = (SW > FIELD_W) ? SW : FIELD_W;

  // Byte store: one write port, one registered read port.
  logic [BYTE_W-1:0] mem [CAPACITY];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [BYTE_W-1:0] rd_data_r;

  gbe_state_t         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [FIELD_W-1:0] off_r, off_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [FIELD_W-1:0] len_r, len_nxt;
  logic [SW-1:0]      tgt_r, tgt_nxt;
  logic [SW-1:0]      del_r, del_nxt;
  logic [SW-1:0]      gap_r, gap_nxt;
  logic [SW-1:0]      size_r, size_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  gbe_res_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Offset arithmetic, all at the common compare width.
  logic [W-1:0]  off_w, size_w, gap_w, len_w;
  logic [W-1:0]  clamp_w, rem_w, dlen_w, phys_w, del_w;
  logic [SW-1:0] glen;
  logic [SW-1:0] gap_dec, dst_left, src_right;

  assign off_w   = W'(off_r);
  assign size_w  = W'(size_r);
  assign gap_w   = W'(gap_r);
  assign len_w   = W'(len_r);
  assign del_w   = W'(del_r);
  assign glen    = SW'(CAPACITY) - size_r;

  // Clamp the offset to the payload, then the delete run to what remains.
  assign clamp_w = (off_w > size_w) ? size_w : off_w;
  assign rem_w   = size_w - clamp_w;
  assign dlen_w  = (len_w > rem_w) ? rem_w : len_w;

  // Logical to physical: offsets at or past the gap skip over it.
  assign phys_w  = (off_w < gap_w) ? off_w : off_w + W'(glen);

  // Gap moving left copies the byte below it to the top of the gap;
  // moving right copies the byte above it to the bottom.
  assign gap_dec   = gap_r - SW'(1);
  assign dst_left  = gap_dec + glen;
  assign src_right = gap_r + glen;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gap_r       <= '0;
      size_r      <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_r       <= gap_nxt;
      size_r      <= size_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    off_r       <= off_nxt;
    byte_r      <= byte_nxt;
    len_r       <= len_nxt;
    tgt_r       <= tgt_nxt;
    del_r       <= del_nxt;
    wr_addr_r   <= wr_addr_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    off_nxt       = off_r;
    byte_nxt      = byte_r;
    len_nxt       = len_r;
    tgt_nxt       = tgt_r;
    del_nxt       = del_r;
    gap_nxt       = gap_r;
    size_nxt      = size_r;
    wr_pend_nxt   = wr_pend_r;
    wr_addr_nxt   = wr_addr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    mem_we        = 1'b0;
    mem_wa        = wr_addr_r;
    mem_wd        = rd_data_r;
    mem_re        = 1'b0;
    mem_ra        = gap_dec[AW-1:0];

    // Drop the output transaction once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[1:0];
          off_nxt   = in_tdata[14:2];
          byte_nxt  = in_tdata[22:15];
          len_nxt   = in_tdata[35:23];
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_nxt   = '0;
        state_nxt = ST_FIN;
        case (op_r)
          OP_READ: begin
            // Issue the store read only for an offset inside the payload.
            if (off_w < size_w) begin
              mem_re    = 1'b1;
              mem_ra    = phys_w[AW-1:0];
              state_nxt = ST_READ;
            end
          end
          OP_INSERT: begin
            if (size_r == SW'(CAPACITY)) begin
              res_nxt.full_res = 1'b1;
            end else begin
              tgt_nxt   = clamp_w[SW-1:0];
              state_nxt = ST_MOVE;
            end
          end
          OP_DELETE: begin
            tgt_nxt   = clamp_w[SW-1:0];
            del_nxt   = dlen_w[SW-1:0];
            state_nxt = ST_MOVE;
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end

      ST_READ: begin
        res_nxt.read_byte  = rd_data_r;
        res_nxt.read_valid = 1'b1;
        state_nxt          = ST_FIN;
      end

      ST_MOVE: begin
        // Complete the copy whose source byte arrived this cycle.
        if (wr_pend_r) begin
          mem_we      = 1'b1;
          mem_wa      = wr_addr_r;
          mem_wd      = rd_data_r;
          wr_pend_nxt = 1'b0;
        end
        if (gap_r == tgt_r) begin
          // Apply the edit only once the write port is free.
          if (!wr_pend_r) begin
            if (op_r == OP_INSERT) begin
              mem_we             = 1'b1;
              mem_wa             = gap_r[AW-1:0];
              mem_wd             = byte_r;
              gap_nxt            = gap_r + SW'(1);
              size_nxt           = size_r + SW'(1);
              res_nxt.done_count = FIELD_W'(1);
            end else begin
              size_nxt           = size_r - del_r;
              res_nxt.done_count = del_w[FIELD_W-1:0];
            end
            state_nxt = ST_FIN;
          end
        end else if (glen == '0) begin
          // No gap bytes: every position maps to itself, nothing to copy.
          gap_nxt = tgt_r;
        end else if (tgt_r < gap_r) begin
          mem_re      = 1'b1;
          mem_ra      = gap_dec[AW-1:0];
          wr_addr_nxt = dst_left[AW-1:0];
          wr_pend_nxt = 1'b1;
          gap_nxt     = gap_dec;
        end else begin
          mem_re      = 1'b1;
          mem_ra      = src_right[AW-1:0];
          wr_addr_nxt = gap_r[AW-1:0];
          wr_pend_nxt = 1'b1;
          gap_nxt     = gap_r + SW'(1);
        end
      end

      ST_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_tdata_nxt = {4'b0000, res_r.full_res, size_w[FIELD_W-1:0],
                           res_r.done_count, res_r.read_valid, res_r.read_byte};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The gap never lies past the payload, nor the payload past the store.
  `GBE_ASSERT_HOLDS(a_gap_in_payload, clk, rst_n, gap_r <= size_r)
  `GBE_ASSERT_HOLDS(a_size_in_store, clk, rst_n, size_r <= SW'(CAPACITY))
  // A copy in flight only exists while the gap travels.
  `GBE_ASSERT_IMPLY(a_pend_in_move, clk, rst_n, wr_pend_r, state_r == ST_MOVE)
  // The payload size changes only when an edit completes.
  `GBE_ASSERT_IMPLY(a_size_at_edit, clk, rst_n, $past(rst_n) && (size_r != $past(size_r)), $past(state_r) == ST_MOVE)
  // A store read result is consumed only right after it was issued.
  `GBE_ASSERT_IMPLY(a_read_after_dec, clk, rst_n, $past(rst_n) && (state_r == ST_READ), $past(state_r) == ST_DECODE)

endmodule
